// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// ===== src/mbrtu_pkg.sv =====
// Package of the Modbus RTU transmit framer: beat types, constants, CRC fold.
// No dependencies.
package mbrtu_pkg;

    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'hA001;
    localparam logic [7:0]  AUTO_BASE_LEN  = 8'd6;
    localparam logic [7:0]  FC_POS         = 8'd1;
    localparam logic [7:0]  MIN_GIVEN_LEN  = 8'd3;
    localparam logic [7:0]  CRC_BYTES      = 8'd2;
    localparam logic [7:0]  SAT_LEN        = 8'hFF;
    localparam logic [7:0]  MWC_RESET      = 8'd15;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] frame_length;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_crc;
        logic       frame_last;
    } out_beat_t;

    // One accepted byte and, when it closes the frame, the CRC to follow it.
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        has_crc;
        logic [15:0] crc;
    } bundle_t;

    typedef enum logic [1:0] {
        PH_DATA,
        PH_CRC_LO,
        PH_CRC_HI
    } phase_t;

    // Byte-wide reflected CRC-16 step, unrolled over the eight bits.
    function automatic logic [15:0] crc_fold(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== src/modbus_rtu_tx_framer.sv =====
// Top level of the Modbus RTU transmit framer: byte forwarding and CRC-16 append.
// Depends on mbrtu_pkg.
//
// Usage: request bytes enter as beats on the s_ channel (valid/ready), each with a
// frame_length field that is only looked at on the first byte of a frame. A value
// of zero selects automatic length detection from the function code and byte count;
// any other value is the full frame length including the two CRC bytes (below 3 reads as 3).
// Every byte leaves on the m_ channel unchanged as a data beat. When a byte closes
// the frame, two more beats follow it: the CRC low byte, then the CRC high byte,
// which carries frame_last. The framer then rearms for the next frame.
// An accepted byte is registered and is shown on m_ from the output register.
// Throughput: one byte per cycle while m_ready is high; a closing byte holds the
// output for three beats, set by the single output register and its beat sequencer.
// A second bundle register lets one more byte be taken while the output is stalled
// or still sending CRC beats; s_ready drops only when that register is also full.
// The user must write the function code threshold through cfg_wr_en / cfg_wr_data only
// while idle; the block does not enforce it. Reset (aresetn low, synchronous) empties
// both registers, restores the threshold to 15 and rearms the frame state with CRC 0xFFFF.
module modbus_rtu_tx_framer (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  mbrtu_pkg::in_beat_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output mbrtu_pkg::out_beat_t m_data,
    input  logic                 cfg_wr_en,
    input  logic [7:0]           cfg_wr_data
);
    import mbrtu_pkg::*;

    // Frame state.
    logic [7:0]  mwc_reg;
    logic [7:0]  byte_count_reg, byte_count_next;
    logic [7:0]  target_reg, target_next;
    logic        auto_reg, auto_next;
    logic        ext_reg, ext_next;
    logic [15:0] crc_reg, crc_next;

    // Output side: the bundle on show and a spare one behind it.
    logic        out_valid_reg, out_valid_next;
    bundle_t     out_bundle_reg, out_bundle_next;
    logic        pend_valid_reg, pend_valid_next;
    bundle_t     pend_bundle_reg, pend_bundle_next;
    phase_t      phase_reg, phase_next;

    logic        accept;
    logic        last_phase;
    logic        out_finish;
    logic        load_out;
    bundle_t     new_bundle;

    assign s_ready = !pend_valid_reg;
    assign accept  = s_valid && s_ready;
    assign m_valid = out_valid_reg;

    // Per-byte framing and CRC update, all in one pass.
    always_comb begin
        logic        first;
        logic [7:0]  b;
        logic [7:0]  flen;
        logic [15:0] crc_base;
        logic [7:0]  tgt;
        logic        auto_m;
        logic        ext;
        logic [8:0]  sum;
        logic [7:0]  cnt;
        logic [15:0] crc_new;
        first    = (byte_count_reg == 8'd0);
        b        = s_data.data_byte;
        flen     = s_data.frame_length;
        crc_base = first ? CRC_INIT : crc_reg;
        ext      = first ? 1'b0 : ext_reg;
        auto_m   = first ? (flen == 8'd0) : auto_reg;
        if (!first) begin
            tgt = target_reg;
        end else if (flen == 8'd0) begin
            tgt = AUTO_BASE_LEN;
        end else if (flen < MIN_GIVEN_LEN) begin
            tgt = MIN_GIVEN_LEN - CRC_BYTES;
        end else begin
            tgt = flen - CRC_BYTES;
        end
        sum = {1'b0, AUTO_BASE_LEN} + 9'd1 + {1'b0, b};
        if (auto_m) begin
            if (byte_count_reg == FC_POS && b >= mwc_reg) begin
                ext = 1'b1;
                tgt = SAT_LEN;
            end else if (byte_count_reg == AUTO_BASE_LEN && ext) begin
                tgt = sum[8] ? SAT_LEN : sum[7:0];
            end
        end
        crc_new = crc_fold(crc_base, b);
        cnt     = byte_count_reg + 8'd1;

        new_bundle.data_byte = b;
        new_bundle.crc       = crc_new;
        new_bundle.has_crc   = (cnt >= tgt);

        byte_count_next = byte_count_reg;
        target_next     = target_reg;
        auto_next       = auto_reg;
        ext_next        = ext_reg;
        crc_next        = crc_reg;
        if (accept) begin
            if (cnt >= tgt) begin
                // Frame closed: rearm.
                byte_count_next = 8'd0;
                target_next     = AUTO_BASE_LEN;
                auto_next       = 1'b1;
                ext_next        = 1'b0;
                crc_next        = CRC_INIT;
            end else begin
                byte_count_next = cnt;
                target_next     = tgt;
                auto_next       = auto_m;
                ext_next        = ext;
                crc_next        = crc_new;
            end
        end
    end

    assign last_phase = (phase_reg == PH_CRC_HI) ||
                        (phase_reg == PH_DATA && !out_bundle_reg.has_crc);
    assign out_finish = out_valid_reg && m_ready && last_phase;

    // Two-slot bundle buffer.
    always_comb begin
        out_valid_next   = out_valid_reg;
        out_bundle_next  = out_bundle_reg;
        pend_valid_next  = pend_valid_reg;
        pend_bundle_next = pend_bundle_reg;
        load_out         = 1'b0;
        if (out_finish) begin
            out_valid_next = 1'b0;
            if (pend_valid_reg) begin
                out_bundle_next = pend_bundle_reg;
                out_valid_next  = 1'b1;
                pend_valid_next = 1'b0;
                load_out        = 1'b1;
            end
        end
        if (accept) begin
            if (!out_valid_reg || out_finish) begin
                out_bundle_next = new_bundle;
                out_valid_next  = 1'b1;
                load_out        = 1'b1;
            end else begin
                pend_bundle_next = new_bundle;
                pend_valid_next  = 1'b1;
            end
        end
    end

    // Beat sequencer: next state.
    always_comb begin
        phase_next = phase_reg;
        if (load_out) begin
            phase_next = PH_DATA;
        end else if (out_valid_reg && m_ready && !last_phase) begin
            case (phase_reg)
                PH_DATA:   phase_next = PH_CRC_LO;
                PH_CRC_LO: phase_next = PH_CRC_HI;
                default:   phase_next = PH_DATA;
            endcase
        end
    end

    // Beat sequencer: outputs.
    always_comb begin
        case (phase_reg)
            PH_CRC_LO: begin
                m_data.out_byte   = out_bundle_reg.crc[7:0];
                m_data.is_crc     = 1'b1;
                m_data.frame_last = 1'b0;
            end
            PH_CRC_HI: begin
                m_data.out_byte   = out_bundle_reg.crc[15:8];
                m_data.is_crc     = 1'b1;
                m_data.frame_last = 1'b1;
            end
            default: begin
                m_data.out_byte   = out_bundle_reg.data_byte;
                m_data.is_crc     = 1'b0;
                m_data.frame_last = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mwc_reg        <= MWC_RESET;
            byte_count_reg <= 8'd0;
            target_reg     <= AUTO_BASE_LEN;
            auto_reg       <= 1'b1;
            ext_reg        <= 1'b0;
            crc_reg        <= CRC_INIT;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            phase_reg      <= PH_DATA;
        end else begin
            if (cfg_wr_en) begin
                mwc_reg <= cfg_wr_data;
            end
            byte_count_reg <= byte_count_next;
            target_reg     <= target_next;
            auto_reg       <= auto_next;
            ext_reg        <= ext_next;
            crc_reg        <= crc_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
            phase_reg      <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_bundle_reg  <= out_bundle_next;
        pend_bundle_reg <= pend_bundle_next;
    end

endmodule

// ===== src/mbrtu_checker.sv =====
// Port-level checks for the Modbus RTU transmit framer, bound to its top level.
// Depends on mbrtu_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mbrtu_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input mbrtu_pkg::out_beat_t m_data
);
    import mbrtu_pkg::*;

    // A stalled result beat keeps its value.
    `ASSERT_CLK(a_m_hold, m_valid && !m_ready |=> m_valid && $stable(m_data), "m beat changed while stalled")

    // The end of a frame is always a CRC byte.
    `ASSERT_CLK(a_last_is_crc, m_valid && m_data.frame_last |-> m_data.is_crc, "frame_last on a data beat")

    // The CRC low byte is followed directly by the CRC high byte.
    `ASSERT_CLK(a_crc_pair, m_valid && m_ready && m_data.is_crc && !m_data.frame_last |=> m_valid && m_data.is_crc && m_data.frame_last, "CRC high byte missing")

    // Reset leaves both sides empty and ready.
    `ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_valid && s_ready, "not empty after reset")

endmodule

bind modbus_rtu_tx_framer mbrtu_checker u_mbrtu_checker (.*);
